/* src/cld_pkg.sv */
// Shared types, constants and helper functions for the content-length deframer.
// Used by every module of the block; depends on nothing else.
package cld_pkg;

	localparam int LENGTH_BITS = 31;
	localparam int PREFIX_LEN = 16;
	localparam int POS_BITS = $clog2(PREFIX_LEN + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [2:0] {
		KIND_BODY       = 3'd0,
		KIND_EMPTY      = 3'd1,
		KIND_NO_LENGTH  = 3'd2,
		KIND_BAD_LENGTH = 3'd3,
		KIND_CUT_SHORT  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		VP_PREFIX = 3'd0,
		VP_BLANKS = 3'd1,
		VP_SIGN   = 3'd2,
		VP_DIGITS = 3'd3,
		VP_DONE   = 3'd4
	} vphase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} result_t;

	// Characters of the "Content-Length: " header prefix.
	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h43;
			4'd1:    c = 8'h6F;
			4'd2:    c = 8'h6E;
			4'd3:    c = 8'h74;
			4'd4:    c = 8'h65;
			4'd5:    c = 8'h6E;
			4'd6:    c = 8'h74;
			4'd7:    c = 8'h2D;
			4'd8:    c = 8'h4C;
			4'd9:    c = 8'h65;
			4'd10:   c = 8'h6E;
			4'd11:   c = 8'h67;
			4'd12:   c = 8'h74;
			4'd13:   c = 8'h68;
			4'd14:   c = 8'h3A;
			default: c = 8'h20;
		endcase
		return c;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
			(b == CH_VT) || (b == CH_FF);
	endfunction

endpackage

/* src/cld_front.sv */
// Front part of the deframer: header scanning, length parsing and body counting.
// Emits at most one classified result per accepted byte. Depends on cld_pkg.
module cld_front import cld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] byte_in,
	input  logic       stream_end,
	output logic       res_valid,
	output result_t    res
);

	logic                   in_body_q, in_body_n;
	logic                   prev_cr_q, prev_cr_n;
	logic [1:0]             crlf_q, crlf_n;
	logic [POS_BITS-1:0]    pos_q, pos_n;
	vphase_t                vp_q, vp_n;
	logic [LENGTH_BITS-1:0] acc_q, acc_n;
	logic                   neg_q, neg_n;
	logic                   dig_q, dig_n;
	logic                   ovf_q, ovf_n;
	logic [LENGTH_BITS-1:0] left_q, left_n;
	logic                   hdr_clr;
	logic                   hdr_load;

	logic                   is_digit;
	logic [LENGTH_BITS+3:0] acc_ext;
	logic [LENGTH_BITS+3:0] prod;

	assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign acc_ext = {4'b0000, acc_q};
	// Times ten as two shifts; the low nibble of an ASCII digit is its value.
	assign prod = (acc_ext << 3) + (acc_ext << 1) + {{LENGTH_BITS{1'b0}}, byte_in[3:0]};

	// Value parser next state.
	always_comb begin
		pos_n = pos_q;
		vp_n = vp_q;
		acc_n = acc_q;
		neg_n = neg_q;
		dig_n = dig_q;
		ovf_n = ovf_q;
		case (vp_q)
			VP_PREFIX: begin
				if (byte_in == prefix_char(pos_q[3:0])) begin
					pos_n = pos_q + POS_BITS'(1);
					if (pos_q == POS_BITS'(PREFIX_LEN - 1))
						vp_n = VP_BLANKS;
				end else begin
					pos_n = (byte_in == prefix_char(4'd0)) ? POS_BITS'(1) : POS_BITS'(0);
				end
			end
			VP_BLANKS, VP_SIGN, VP_DIGITS: begin
				if (vp_q == VP_BLANKS && is_blank(byte_in)) begin
					vp_n = VP_BLANKS;
				end else if (vp_q == VP_BLANKS &&
						(byte_in == CH_PLUS || byte_in == CH_MINUS)) begin
					neg_n = neg_q | (byte_in == CH_MINUS);
					vp_n = VP_SIGN;
				end else if (is_digit) begin
					dig_n = 1'b1;
					vp_n = VP_DIGITS;
					if (!ovf_q) begin
						if (|prod[LENGTH_BITS+3:LENGTH_BITS])
							ovf_n = 1'b1;
						else
							acc_n = prod[LENGTH_BITS-1:0];
					end
				end else begin
					vp_n = VP_DONE;
				end
			end
			default: begin
				vp_n = vp_q;
			end
		endcase
	end

	// Line-end counting, body counting and result classification.
	always_comb begin
		res_valid = 1'b0;
		res = '{kind: KIND_BODY, data: 8'h00, last: 1'b0};
		in_body_n = in_body_q;
		left_n = left_q;
		prev_cr_n = (byte_in == CH_CR);
		crlf_n = crlf_q;
		hdr_clr = 1'b0;
		hdr_load = 1'b0;
		if (stream_end) begin
			res_valid = in_body_q;
			res.kind = KIND_CUT_SHORT;
			in_body_n = 1'b0;
			left_n = '0;
			hdr_clr = 1'b1;
		end else if (in_body_q) begin
			res_valid = 1'b1;
			res.data = byte_in;
			if (left_q <= LENGTH_BITS'(1)) begin
				res.last = 1'b1;
				left_n = '0;
				in_body_n = 1'b0;
			end else begin
				left_n = left_q - LENGTH_BITS'(1);
			end
		end else begin
			hdr_load = 1'b1;
			if (byte_in == CH_CR)
				crlf_n = crlf_q;
			else if (byte_in == CH_LF)
				crlf_n = crlf_q + {1'b0, prev_cr_q};
			else
				crlf_n = 2'd0;
			if (crlf_n == 2'd2) begin
				hdr_clr = 1'b1;
				if (vp_n == VP_PREFIX) begin
					res_valid = 1'b1;
					res.kind = KIND_NO_LENGTH;
				end else if (!dig_n || ovf_n || (neg_n && acc_n != '0)) begin
					res_valid = 1'b1;
					res.kind = KIND_BAD_LENGTH;
				end else if (acc_n == '0) begin
					res_valid = 1'b1;
					res.kind = KIND_EMPTY;
				end else begin
					in_body_n = 1'b1;
					left_n = acc_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			left_q <= '0;
			prev_cr_q <= 1'b0;
			crlf_q <= 2'd0;
			pos_q <= '0;
			vp_q <= VP_PREFIX;
			acc_q <= '0;
			neg_q <= 1'b0;
			dig_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (take) begin
			in_body_q <= in_body_n;
			left_q <= left_n;
			if (hdr_clr) begin
				prev_cr_q <= 1'b0;
				crlf_q <= 2'd0;
				pos_q <= '0;
				vp_q <= VP_PREFIX;
				acc_q <= '0;
				neg_q <= 1'b0;
				dig_q <= 1'b0;
				ovf_q <= 1'b0;
			end else if (hdr_load) begin
				prev_cr_q <= prev_cr_n;
				crlf_q <= crlf_n;
				pos_q <= pos_n;
				vp_q <= vp_n;
				acc_q <= acc_n;
				neg_q <= neg_n;
				dig_q <= dig_n;
				ovf_q <= ovf_n;
			end
		end
	end

	// The header state is always clean while a body is being passed.
	a_body_hdr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> (crlf_q == 2'd0 && vp_q == VP_PREFIX && !prev_cr_q && pos_q == '0))
		else $error("header state not cleared in body phase");

	// Two line ends always close the header at once, so the count never rests at two.
	a_crlf_low: assert property (@(posedge clk) disable iff (!arst_n)
		crlf_q[1] == 1'b0)
		else $error("line-end count left at two or more");

	// A body never starts or stays with nothing left to pass.
	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> left_q != '0)
		else $error("body phase with zero bytes left");

	// No value flags or digits before the prefix has been found.
	a_prefix_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(vp_q == VP_PREFIX) |-> (acc_q == '0 && !neg_q && !dig_q && !ovf_q))
		else $error("value state set before prefix match");

endmodule

/* src/cld_queue.sv */
// Two-entry result queue between the deframer front and its output stage.
// Depends on cld_pkg for the result type and depth constants.
module cld_queue import cld_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	input  logic    pop,
	output result_t dout,
	output logic    not_empty,
	output logic    full
);

	result_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 do_pop;

	assign not_empty = (cnt_q != '0);
	assign full = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign do_pop = pop && not_empty;
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_BITS'(1);
			if (do_pop)
				rd_q <= (rd_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_BITS'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + QCNT_BITS'(1);
			else if (!push && do_pop)
				cnt_q <= cnt_q - QCNT_BITS'(1);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into a full queue");

	a_cnt_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> cnt_q == $past(cnt_q) + QCNT_BITS'(1))
		else $error("queue count did not follow a push");

endmodule

/* src/cld_back.sv */
// Output stage of the deframer: pops the result queue into the output register.
// Depends on cld_pkg for the result type.
module cld_back import cld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_not_empty,
	input  result_t    q_data,
	output logic       pop,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] kind,
	output logic [7:0] body_byte,
	output logic       last_byte
);

	logic    valid_q;
	result_t out_q;

	// The register takes a new result when it is empty or its current one transfers.
	assign pop = q_not_empty && (!valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || !result_stall)
			valid_q <= q_not_empty;
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= q_data;
	end

	assign result_valid = valid_q;
	assign kind = out_q.kind;
	assign body_byte = out_q.data;
	assign last_byte = out_q.last;

endmodule

/* src/content_length_deframer.sv */
// Content-length deframer: splits a byte stream into header-framed messages.
// Top level; instantiates cld_front, cld_queue and cld_back; uses cld_pkg.
//
// Input channel: one stream byte (byte_in) or an end-of-stream marker
// (stream_end) per transfer, on byte_valid / byte_stall. Output channel: one
// result per transfer on result_valid / result_stall: a body byte (kind 0,
// last_byte on the final one), an empty body, a missing length, a bad length,
// or a body cut short by end of stream. Header bytes give no result until the
// header ends with two CR LF pairs.
// Throughput is one byte per cycle while byte_stall is low: the front updates all
// parse state of a byte together, with the times-ten step of the length value done as
// shifts and one add. The result of an input transfer passes from the front into the
// two-entry queue, then from the queue into the output register.
// When the receiver stalls, the output register holds its result and the
// queue fills; byte_stall rises once the queue is full and drops as soon as
// an entry leaves. Reset empties the queue and output register and returns
// the parser to the start of a header.
module content_length_deframer import cld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] byte_in,
	input  logic       stream_end,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] kind,
	output logic [7:0] body_byte,
	output logic       last_byte
);

	logic    take;
	logic    res_valid;
	result_t res;
	logic    q_full;
	logic    q_not_empty;
	result_t q_data;
	logic    pop;

	assign byte_stall = q_full;
	assign take = byte_valid && !q_full;

	cld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.byte_in    (byte_in),
		.stream_end (stream_end),
		.res_valid  (res_valid),
		.res        (res)
	);

	cld_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && res_valid),
		.din       (res),
		.pop       (pop),
		.dout      (q_data),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	cld_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_data       (q_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.body_byte    (body_byte),
		.last_byte    (last_byte)
	);

endmodule

/* verif/tb.sv */
// Self-checking testbench for content_length_deframer.
// Drives framed byte streams and end-of-stream markers and checks every result transfer
// against an in-bench model of the parser. Depends on cld_pkg and the block's RTL.
module tb import cld_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_ITEMS = 650;
	localparam int N_MSG_KINDS = 10;
	localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS) - 1;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_QUIET,
		ROW_RESULT
	} row_check_t;

	typedef struct packed {
		logic [7:0] b;
		logic       e;
		row_check_t chk;
		kind_t      kind;
	} row_t;

	typedef struct packed {
		logic [7:0] b;
		logic       e;
	} feed_t;

	typedef enum int {
		MSG_GOOD,
		MSG_CUT,
		MSG_ZERO,
		MSG_NEG,
		MSG_NODIGIT,
		MSG_OVERFLOW,
		MSG_MAX,
		MSG_MISSING,
		MSG_HDR_END,
		MSG_NOISE
	} msg_kind_t;

	// Header-end rules: end marker in the header, LF without CR, lone CR,
	// a pair broken by another byte, then two plain headers with no length.
	localparam row_t DIRECTED_ROWS [16] = '{
		'{8'hFF, 1'b1, ROW_QUIET,  KIND_BODY},
		'{8'h00, 1'b0, ROW_QUIET,  KIND_BODY},
		'{8'h0A, 1'b0, ROW_QUIET,  KIND_BODY},
		'{8'h0D, 1'b0, ROW_QUIET,  KIND_BODY},
		'{8'h0D, 1'b0, ROW_QUIET,  KIND_BODY},
		'{8'h0A, 1'b0, ROW_QUIET,  KIND_BODY},
		'{8'hFF, 1'b0, ROW_QUIET,  KIND_BODY},
		'{8'h0D, 1'b0, ROW_QUIET,  KIND_BODY},
		'{8'h0A, 1'b0, ROW_QUIET,  KIND_BODY},
		'{8'h0D, 1'b0, ROW_QUIET,  KIND_BODY},
		'{8'h0A, 1'b0, ROW_RESULT, KIND_NO_LENGTH},
		'{8'h0D, 1'b0, ROW_QUIET,  KIND_BODY},
		'{8'h0A, 1'b0, ROW_QUIET,  KIND_BODY},
		'{8'h0D, 1'b0, ROW_QUIET,  KIND_BODY},
		'{8'h0A, 1'b0, ROW_RESULT, KIND_NO_LENGTH},
		'{8'h00, 1'b1, ROW_QUIET,  KIND_BODY}
	};

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	logic [7:0] byte_in;
	logic       stream_end;
	logic       result_valid;
	logic       result_stall;
	logic [2:0] kind;
	logic [7:0] body_byte;
	logic       last_byte;

	content_length_deframer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_in      (byte_in),
		.stream_end   (stream_end),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.body_byte    (body_byte),
		.last_byte    (last_byte)
	);

	// Parser state of the model.
	bit              body_active;
	longint unsigned body_left;
	bit              hdr_prev_cr;
	int              hdr_crlf;
	int              pfx_pos;
	vphase_t         vphase;
	longint unsigned len_value;
	bit              len_neg;
	bit              len_digit;
	bit              len_ovf;
	string           len_prefix = "Content-Length: ";

	result_t due_results [$];
	feed_t   feed_q [$];
	int      idle_pct;
	int      stall_pct;
	int      sent;
	int      fail_count;
	int      n_results;
	int      n_body_ends;
	int      n_reports;
	int      n_messages;

	function automatic void clear_header();
		hdr_prev_cr = 0;
		hdr_crlf = 0;
		pfx_pos = 0;
		vphase = VP_PREFIX;
		len_value = 0;
		len_neg = 0;
		len_digit = 0;
		len_ovf = 0;
	endfunction

	function automatic void reset_parser();
		body_active = 0;
		body_left = 0;
		clear_header();
	endfunction

	function automatic void add_digit(input logic [7:0] b);
		longint unsigned v;
		len_digit = 1;
		if (len_ovf)
			return;
		v = len_value * 10 + longint'(b - CH_ZERO);
		if (v > LEN_MAX)
			len_ovf = 1;
		else
			len_value = v;
	endfunction

	// Advances the model by one transfer; returns 1 when the transfer yields a result.
	function automatic bit deframe_byte(input logic [7:0] b, input logic e, output result_t r);
		bit was_body;
		bit is_digit;
		bit is_blank_ch;
		r = '{KIND_BODY, 8'h00, 1'b0};
		if (e) begin
			was_body = body_active;
			reset_parser();
			if (was_body)
				r.kind = KIND_CUT_SHORT;
			return was_body;
		end
		if (body_active) begin
			r.data = b;
			if (body_left <= 1) begin
				r.last = 1;
				body_left = 0;
				body_active = 0;
			end else begin
				body_left--;
			end
			return 1;
		end
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		is_blank_ch = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
			(b == CH_VT) || (b == CH_FF);
		case (vphase)
			VP_PREFIX: begin
				if (pfx_pos < PREFIX_LEN && b == len_prefix[pfx_pos]) begin
					pfx_pos++;
					if (pfx_pos == PREFIX_LEN)
						vphase = VP_BLANKS;
				end else begin
					pfx_pos = (b == len_prefix[0]) ? 1 : 0;
				end
			end
			VP_BLANKS: begin
				if (!is_blank_ch) begin
					if (b == CH_PLUS || b == CH_MINUS) begin
						len_neg = (b == CH_MINUS);
						vphase = VP_SIGN;
					end else if (is_digit) begin
						add_digit(b);
						vphase = VP_DIGITS;
					end else begin
						vphase = VP_DONE;
					end
				end
			end
			VP_SIGN, VP_DIGITS: begin
				if (is_digit) begin
					add_digit(b);
					vphase = VP_DIGITS;
				end else begin
					vphase = VP_DONE;
				end
			end
			default: ;
		endcase
		if (b == CH_LF) begin
			if (hdr_prev_cr)
				hdr_crlf++;
		end else if (b != CH_CR) begin
			hdr_crlf = 0;
		end
		hdr_prev_cr = (b == CH_CR);
		if (hdr_crlf < 2)
			return 0;
		if (vphase == VP_PREFIX)
			r.kind = KIND_NO_LENGTH;
		else if (!len_digit || len_ovf || (len_neg && len_value != 0))
			r.kind = KIND_BAD_LENGTH;
		else if (len_value == 0)
			r.kind = KIND_EMPTY;
		else begin
			body_left = len_value;
			body_active = 1;
		end
		clear_header();
		return !body_active;
	endfunction

	task automatic push_item(input logic [7:0] b, input logic e);
		feed_t f;
		f.b = b;
		f.e = e;
		feed_q.insert(feed_q.size(), f);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_item(s[i], 1'b0);
	endtask

	task automatic push_junk(input int lo, input int hi);
		int n;
		n = $urandom_range(hi, lo);
		for (int i = 0; i < n; i++)
			push_item(8'($urandom_range(126, 33)), 1'b0);
	endtask

	task automatic push_blanks();
		int n;
		n = $urandom_range(2);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(4))
				0: push_item(CH_SPACE, 1'b0);
				1: push_item(CH_TAB, 1'b0);
				2: push_item(CH_LF, 1'b0);
				3: push_item(CH_VT, 1'b0);
				default: push_item(CH_FF, 1'b0);
			endcase
		end
	endtask

	task automatic push_body(input int n);
		for (int i = 0; i < n; i++)
			push_item(8'($urandom_range(255)), 1'b0);
	endtask

	function automatic string length_text(input int n);
		case ($urandom_range(3))
			0: return $sformatf("+%0d", n);
			1: return $sformatf("0%0d", n);
			default: return $sformatf("%0d", n);
		endcase
	endfunction

	// Queues a message of the given flavor: headers, length and body, or bytes then an end.
	task automatic build_message(input msg_kind_t m);
		int n;
		string val;
		n_messages++;
		if (m == MSG_NOISE) begin
			n = $urandom_range(16, 4);
			push_body(n);
			push_item(8'($urandom_range(255)), 1'b1);
			return;
		end
		if (m == MSG_HDR_END) begin
			push_text("Content-Le");
			push_item(8'($urandom_range(255)), 1'b1);
			return;
		end
		if ($urandom_range(3) == 0) begin
			push_junk(1, 8);
			push_text("\r\n");
		end
		n = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
		case (m)
			MSG_GOOD:    val = length_text(n);
			MSG_CUT: begin
				n = $urandom_range(12, 2);
				val = length_text(n);
			end
			MSG_ZERO: begin
				case ($urandom_range(3))
					0: val = "0";
					1: val = "-0";
					2: val = "+0";
					default: val = "000";
				endcase
			end
			MSG_NEG:     val = $sformatf("-%0d", $urandom_range(5000, 1));
			MSG_NODIGIT: begin
				case ($urandom_range(4))
					0: val = "";
					1: val = "+";
					2: val = "-";
					3: val = "x5";
					default: val = "+-3";
				endcase
			end
			MSG_OVERFLOW: begin
				case ($urandom_range(3))
					0: val = "2147483648";
					1: val = "4294967296";
					2: val = "-99999999999";
					default: val = $sformatf("%0d%0d", $urandom_range(9, 1),
						$urandom_range(2000000000, 1000000000));
				endcase
			end
			MSG_MAX:     val = "2147483647";
			default:     val = "";
		endcase
		if (m == MSG_MISSING) begin
			// A near miss on the prefix, then an ordinary header line.
			push_text("Content-Length:5");
			push_text("\r\n");
			push_junk(1, 8);
		end else begin
			// A partial prefix that restarts on its own first character.
			if ($urandom_range(4) == 0)
				push_text("CContent-Len");
			push_text(len_prefix);
			push_blanks();
			push_text(val);
		end
		if ($urandom_range(3) == 0)
			push_junk(1, 4);
		push_text("\r\n");
		if ($urandom_range(3) == 0) begin
			push_junk(1, 8);
			push_text("\r\n");
		end
		if ($urandom_range(4) == 0)
			push_item(CH_CR, 1'b0);
		push_text("\r\n");
		case (m)
			MSG_GOOD: push_body(n);
			MSG_CUT: begin
				push_body($urandom_range(n - 1, 1));
				push_item(8'($urandom_range(255)), 1'b1);
			end
			MSG_MAX: begin
				push_body($urandom_range(6));
				push_item(8'($urandom_range(255)), 1'b1);
			end
			default: ;
		endcase
	endtask

	// Presents one transfer and records what it should yield once it is taken.
	task automatic send_item(input feed_t f, input row_check_t chk, input kind_t typed_kind);
		bit produced;
		result_t r;
		while ($urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_in <= f.b;
		stream_end <= f.e;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		produced = deframe_byte(f.b, f.e, r);
		case (chk)
			ROW_PREDICT: begin
				if (produced)
					due_results.insert(due_results.size(), r);
			end
			ROW_RESULT: begin
				r = '{typed_kind, 8'h00, 1'b0};
				due_results.insert(due_results.size(), r);
			end
			default: ;
		endcase
		sent++;
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(negedge clk)
		result_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (kind != KIND_BODY)
				n_reports++;
			if (last_byte)
				n_body_ends++;
			if (due_results.size() == 0) begin
				$error("unexpected result transfer: kind %0d byte %02h last %0b",
					kind, body_byte, last_byte);
				fail_count++;
			end else begin
				exp_r = due_results.pop_front();
				if (kind !== exp_r.kind) begin
					$error("kind: expected %0d, got %0d", exp_r.kind, kind);
					fail_count++;
				end
				if (body_byte !== exp_r.data) begin
					$error("body_byte: expected %02h, got %02h", exp_r.data, body_byte);
					fail_count++;
				end
				if (last_byte !== exp_r.last) begin
					$error("last_byte: expected %0b, got %0b", exp_r.last, last_byte);
					fail_count++;
				end
			end
		end
	end

	initial begin
		feed_t f;
		int ph;
		int cur_phase;
		msg_kind_t m;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_in = 8'h00;
		stream_end = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		cur_phase = 0;
		reset_parser();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			f.b = DIRECTED_ROWS[i].b;
			f.e = DIRECTED_ROWS[i].e;
			send_item(f, DIRECTED_ROWS[i].chk, DIRECTED_ROWS[i].kind);
		end

		while (sent < TOTAL_ITEMS || feed_q.size() != 0) begin
			ph = sent * 4 / TOTAL_ITEMS;
			if (ph > 3)
				ph = 3;
			if (ph != cur_phase) begin
				cur_phase = ph;
				case (ph)
					1: begin idle_pct = 79; stall_pct = 0; end
					2: begin idle_pct = 0; stall_pct = 79; end
					default: begin idle_pct = 34; stall_pct = 34; end
				endcase
				// Hold the input off until every outstanding result has drained.
				byte_valid <= 1'b0;
				do
					@(negedge clk);
				while (due_results.size() != 0);
			end
			if (feed_q.size() == 0) begin
				if (n_messages < N_MSG_KINDS)
					m = msg_kind_t'(n_messages);
				else if ($urandom_range(1) == 1)
					m = MSG_GOOD;
				else
					m = msg_kind_t'($urandom_range(N_MSG_KINDS - 1));
				build_message(m);
			end
			f = feed_q.pop_front();
			send_item(f, ROW_PREDICT, KIND_BODY);
		end

		byte_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d transfers in %0d messages under four idling mixes.",
			sent, n_messages);
		$display("Checked %0d results: %0d complete bodies, %0d status reports.",
			n_results, n_body_ends, n_reports);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
